FILE: rtl/wbpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbpp_pkg
// shared types and constants of the wildcard byte pattern patcher
// ----------------------------------------------------------------------------
package wbpp_pkg;

    // window and table depth
    localparam int MAX_PATTERN = 64;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    // fixed field widths
    localparam int CFG_LEN_W = 7;
    localparam int TIDX_W    = 6;
    localparam int OFS_W     = 32;

    // pattern byte that matches anything but at the first position, replacement byte that keeps the data
    localparam logic [7:0] WILDCARD = 8'h3F;

    // request codes on the input channel
    localparam logic [1:0] REQ_LOAD_PAT = 2'd0;
    localparam logic [1:0] REQ_LOAD_REP = 2'd1;
    localparam logic [1:0] REQ_DATA     = 2'd2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TIDX_W-1:0] table_index;
        logic [7:0]        byte_value;
        logic              stream_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_last;
        logic             match_found;
        logic [OFS_W-1:0] match_offset;
    } t_out_item;

    typedef struct packed {
        logic                 patch_enable;
        logic [CFG_LEN_W-1:0] pattern_length;
        logic [CFG_LEN_W-1:0] replacement_length;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_PAT  = 2'd0,
        CMD_REP  = 2'd1,
        CMD_DATA = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [TIDX_W-1:0] table_index;
        logic [7:0]        byte_value;
        logic              stream_last;
    } t_cmd;

endpackage

FILE: rtl/wildcard_byte_pattern_patcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_patcher_core
// streaming wildcard signature search and in-place patch of a byte stream
// ----------------------------------------------------------------------------
// Bytes enter on the input channel, one beat per cycle while the queue is not
// full, and leave through a window as long as the pattern. Pattern and
// replacement bytes are loaded by beats on the same channel, in order with the
// data. A steady stream moves one byte per cycle in and one out while the
// output is not stalled; the compare of the whole window against the pattern
// is a single parallel step. The final byte of a stream leaves bytes in the
// window, so that beat is followed by a drain of the window during which no
// new beat is taken from the queue; shortening the pattern length in the
// middle of a stream likewise drains the surplus bytes.
// The input side sees this only once the four-entry command queue fills. A
// byte passes from the queue head through the window to the output register.
// Pattern and replacement tables power up undefined and must be loaded before
// use. Registers: patch_enable at 0x0, pattern_length at 0x4,
// replacement_length at 0x8; write them only while no beat is in flight.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_patcher_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    input  wbpp_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    // output channel
    output logic                o_out_valid,
    output wbpp_pkg::t_out_item o_out_data,
    input  logic                i_out_stall,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import wbpp_pkg::*;

    // register word indexes
    localparam logic [1:0] REG_PATCH_EN = 2'd0;
    localparam logic [1:0] REG_PAT_LEN  = 2'd1;
    localparam logic [1:0] REG_REP_LEN  = 2'd2;

    logic                 r_patch_enable;
    logic [CFG_LEN_W-1:0] r_pattern_length;
    logic [CFG_LEN_W-1:0] r_replacement_length;
    t_cfg                 cfg;
    logic                 cfg_wr;

    logic push;
    t_cmd push_data;
    logic q_full;
    logic q_valid;
    t_cmd q_data;
    logic q_pop;

    // register port: always ready, write on the access beat
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_enable       <= 1'b0;
            r_pattern_length     <= CFG_LEN_W'(1);
            r_replacement_length <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_PATCH_EN: r_patch_enable       <= pwdata[0];
                REG_PAT_LEN:  r_pattern_length     <= pwdata[CFG_LEN_W-1:0];
                REG_REP_LEN:  r_replacement_length <= pwdata[CFG_LEN_W-1:0];
                default: begin
                    // unmapped word, write dropped
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PATCH_EN: prdata = 32'(r_patch_enable);
            REG_PAT_LEN:  prdata = 32'(r_pattern_length);
            REG_REP_LEN:  prdata = 32'(r_replacement_length);
            default:      prdata = '0;
        endcase
    end

    assign cfg.patch_enable       = r_patch_enable;
    assign cfg.pattern_length     = r_pattern_length;
    assign cfg.replacement_length = r_replacement_length;

    // front: accept and classify beats
    wbpp_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (q_full)
    );

    // decoupling queue
    wbpp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (q_pop)
    );

    // back: window, match, patch and output stage
    wbpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_data),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: rtl/wbpp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbpp_front
// accepts input beats, classifies them and pushes commands into the queue
// ----------------------------------------------------------------------------
module wbpp_front (
    input  logic                i_in_valid,
    input  wbpp_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_push,
    output wbpp_pkg::t_cmd      o_push_data,
    input  logic                i_full
);
    import wbpp_pkg::*;

    logic keep;

    always_comb begin
        keep                    = 1'b1;
        o_push_data.kind        = CMD_DATA;
        o_push_data.table_index = i_in_data.table_index;
        o_push_data.byte_value  = i_in_data.byte_value;
        o_push_data.stream_last = i_in_data.stream_last;
        unique case (i_in_data.req_type)
            REQ_LOAD_PAT: begin
                o_push_data.kind = CMD_PAT;
            end
            REQ_LOAD_REP: begin
                o_push_data.kind = CMD_REP;
            end
            REQ_DATA: begin
                o_push_data.kind = CMD_DATA;
            end
            default: begin
                // unknown request, dropped
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full && keep;

endmodule

FILE: rtl/wbpp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbpp_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module wbpp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wbpp_pkg::t_cmd  i_push_data,
    output logic            o_full,
    output logic            o_valid,
    output wbpp_pkg::t_cmd  o_data,
    input  logic            i_pop
);
    import wbpp_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QLVL_W-1:0] r_level;

    assign o_full  = (r_level == QLVL_W'(QUEUE_DEPTH));
    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

FILE: rtl/wbpp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbpp_back
// pattern tables, byte window, match and patch, drain sequencer, output stage
// ----------------------------------------------------------------------------
module wbpp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wbpp_pkg::t_cfg      i_cfg,
    input  logic                i_cmd_valid,
    input  wbpp_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    output wbpp_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import wbpp_pkg::*;

    typedef enum logic [2:0] {
        S_RUN    = 3'b001,
        S_FLUSH  = 3'b010,
        S_SHRINK = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [7:0]       r_pat [MAX_PATTERN];
    logic [7:0]       r_rep [MAX_PATTERN];
    logic [7:0]       r_win [MAX_PATTERN];
    logic [LEN_W-1:0] r_count, n_count;
    logic             r_found, n_found;
    logic [OFS_W-1:0] r_pos, n_pos;
    logic [OFS_W-1:0] r_offset, n_offset;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       rep_len;
    logic [LEN_W-1:0]       cnt_app;
    logic                   can_emit;
    logic                   is_data;
    logic [MAX_PATTERN-1:0] match_vec;
    logic                   hit;
    logic [7:0]             w_app [MAX_PATTERN];
    logic [7:0]             w_pat [MAX_PATTERN];
    logic [7:0]             win_src [MAX_PATTERN];
    logic                   use_app;
    logic                   win_we;
    logic                   shift;
    logic                   emit;
    t_out_item              emit_data;
    logic                   found_now;
    logic [OFS_W-1:0]       off_now;

    // effective window length and clamped replacement length
    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (int'(i_cfg.pattern_length) > MAX_PATTERN) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = LEN_W'(i_cfg.pattern_length);
        end
        if (int'(i_cfg.replacement_length) > int'(eff_len)) begin
            rep_len = eff_len;
        end else begin
            rep_len = LEN_W'(i_cfg.replacement_length);
        end
    end

    assign can_emit = !r_out_valid || !i_out_stall;
    assign is_data  = (i_cmd.kind == CMD_DATA);
    assign cnt_app  = r_count + 1'b1;

    // window with the new byte appended, parallel compare, patch
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_app[i] = (IDX_W'(i) == r_count[IDX_W-1:0]) ? i_cmd.byte_value : r_win[i];
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (LEN_W'(j) >= eff_len) begin
                match_vec[j] = 1'b1;
            end else if (j == 0) begin
                // first position is always literal
                match_vec[j] = (w_app[j] == r_pat[j]);
            end else begin
                match_vec[j] = (w_app[j] == r_pat[j]) || (r_pat[j] == WILDCARD);
            end
        end
        hit = is_data && i_cfg.patch_enable && !r_found && (cnt_app >= eff_len)
              && (&match_vec);
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (hit && (LEN_W'(i) < rep_len) && (r_rep[i] != WILDCARD)) begin
                w_pat[i] = r_rep[i];
            end else begin
                w_pat[i] = w_app[i];
            end
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_found   = r_found;
        n_pos     = r_pos;
        n_offset  = r_offset;
        o_cmd_pop = 1'b0;
        use_app   = 1'b0;
        win_we    = 1'b0;
        shift     = 1'b0;
        emit      = 1'b0;
        found_now = r_found;
        off_now   = r_offset;
        emit_data.out_byte = r_win[0];
        emit_data.out_last = 1'b0;
        unique case (r_state)
            S_RUN: begin
                if (i_cmd_valid && can_emit) begin
                    o_cmd_pop = 1'b1;
                    if (is_data) begin
                        use_app   = 1'b1;
                        win_we    = 1'b1;
                        found_now = r_found | hit;
                        off_now   = hit ? (r_pos - OFS_W'(r_count)) : r_offset;
                        n_found   = found_now;
                        n_offset  = off_now;
                        emit_data.out_byte = w_pat[0];
                        if (i_cmd.stream_last || (cnt_app >= eff_len)) begin
                            emit    = 1'b1;
                            shift   = 1'b1;
                            n_count = r_count;
                            emit_data.out_last = i_cmd.stream_last && (r_count == '0);
                        end else begin
                            n_count = cnt_app;
                        end
                        if (i_cmd.stream_last) begin
                            n_pos = '0;
                            if (r_count == '0) begin
                                n_found  = 1'b0;
                                n_offset = '0;
                            end else begin
                                n_state = S_FLUSH;
                            end
                        end else begin
                            n_pos = r_pos + 1'b1;
                            // pattern length was shortened: drain the extra bytes
                            if ((cnt_app >= eff_len) && (r_count >= eff_len)) begin
                                n_state = S_SHRINK;
                            end
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    shift   = 1'b1;
                    win_we  = 1'b1;
                    n_count = r_count - 1'b1;
                    emit_data.out_last = (r_count == LEN_W'(1));
                    if (r_count == LEN_W'(1)) begin
                        n_state  = S_RUN;
                        n_found  = 1'b0;
                        n_offset = '0;
                    end
                end
            end
            S_SHRINK: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    shift   = 1'b1;
                    win_we  = 1'b1;
                    n_count = r_count - 1'b1;
                    if (r_count <= eff_len) begin
                        n_state = S_RUN;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
        emit_data.match_found  = found_now;
        emit_data.match_offset = found_now ? off_now : '0;
    end

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            win_src[i] = use_app ? w_pat[i] : r_win[i];
        end
    end

    // tables and window: payload only
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.kind == CMD_PAT) && (int'(i_cmd.table_index) < MAX_PATTERN)) begin
            r_pat[IDX_W'(i_cmd.table_index)] <= i_cmd.byte_value;
        end
        if (o_cmd_pop && (i_cmd.kind == CMD_REP) && (int'(i_cmd.table_index) < MAX_PATTERN)) begin
            r_rep[IDX_W'(i_cmd.table_index)] <= i_cmd.byte_value;
        end
        if (win_we) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                r_win[i] <= shift ? win_src[i+1] : win_src[i];
            end
            r_win[MAX_PATTERN-1] <= win_src[MAX_PATTERN-1];
        end
        if (emit) begin
            r_out_data <= emit_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_pos       <= '0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_found  <= n_found;
            r_pos    <= n_pos;
            r_offset <= n_offset;
            if (can_emit) begin
                r_out_valid <= emit;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_W'(MAX_PATTERN))
        else $error("window count beyond depth");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FLUSH |-> r_count != '0)
        else $error("flush with empty window");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data.match_found |-> r_out_data.match_offset == '0)
        else $error("offset reported without match");

    a_found_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_found) |-> $past(i_cfg.patch_enable))
        else $error("match taken with patching disabled");

endmodule
